// ===== design/tiered_inactivity_power_manager_unit_defines.svh =====
// Assertion macros for the power manager block.
// Both macros sample on posedge clk and are disabled while rst_n is low.
`ifndef TIERED_INACTIVITY_POWER_MANAGER_UNIT_DEFINES_SVH
`define TIERED_INACTIVITY_POWER_MANAGER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TIPM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tipm assertion failed");

// Next-cycle implication.
`define TIPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tipm assertion failed");

`else

`define TIPM_ASSERT_IMP(label, ante, cons)
`define TIPM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/tipm_pkg.sv =====
`timescale 1ns / 1ps

package tipm_pkg;

    localparam int LOCK_BITS_DEF = 8;
    localparam int LOCK_IN_W     = 8;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int COUNT_W       = 16;
    localparam int LEVEL_W       = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [15:0]        DIM_AFTER_RST   = 16'd10000;
    localparam logic [15:0]        OFF_AFTER_RST   = 16'd15000;
    localparam logic [15:0]        SLEEP_AFTER_RST = 16'd20000;
    localparam logic [LEVEL_W-1:0] SAVED_RST     = 8'd255;
    localparam logic [LEVEL_W-1:0] DIM_FLOOR     = 8'd10;
    localparam int                 DIM_SHIFT     = 2;  // divide by four

    typedef enum logic [1:0] {
        TIER_ACTIVE = 2'd0,
        TIER_DIM    = 2'd1,
        TIER_OFF    = 2'd2,
        TIER_SLEEP  = 2'd3
    } tier_t;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_TOUCH    = 2'd1,
        KIND_LOCK_SET = 2'd2,
        KIND_LOCK_CLR = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_AFTER   = 8'd0,
        CFG_OFF_AFTER   = 8'd1,
        CFG_SLEEP_AFTER = 8'd2,
        CFG_SLEEP_EN    = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        kind_t                  kind;
        logic [LOCK_IN_W-1:0]   lock_bits;
        logic                   wifi_busy;
        logic [LEVEL_W-1:0]     brightness_now;
    } item_t;

    typedef struct packed {
        tier_t                  tier;
        logic                   backlight_write;
        logic [LEVEL_W-1:0]     backlight_level;
        logic                   panel_on;
        logic                   sleep_request;
        logic                   touch_recal;
        logic                   display_showing;
    } result_t;

    typedef struct packed {
        logic [15:0]            dim_after_ms;
        logic [15:0]            off_after_ms;
        logic [15:0]            sleep_after_ms;
        logic                   sleep_enabled;
    } cfg_t;

    typedef struct packed {
        tier_t                  tier;
        logic [COUNT_W-1:0]     idle_count;
        logic [LEVEL_W-1:0]     saved_level;
        logic                   panel_state;
    } pm_state_t;

endpackage

// ===== design/tipm_if.sv =====
`timescale 1ns / 1ps

interface tipm_item_if import tipm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [LOCK_IN_W-1:0]   lock_bits;
    logic                   wifi_busy;
    logic [LEVEL_W-1:0]     brightness_now;

    modport source (output valid, kind, lock_bits, wifi_busy, brightness_now, input ready);
    modport sink (input valid, kind, lock_bits, wifi_busy, brightness_now, output ready);
endinterface

interface tipm_result_if import tipm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             tier;
    logic                   backlight_write;
    logic [LEVEL_W-1:0]     backlight_level;
    logic                   panel_on;
    logic                   sleep_request;
    logic                   touch_recal;
    logic                   display_showing;

    modport source (output valid, tier, backlight_write, backlight_level, panel_on,
                    sleep_request, touch_recal, display_showing, input ready);
    modport sink (input valid, tier, backlight_write, backlight_level, panel_on,
                  sleep_request, touch_recal, display_showing, output ready);
endinterface

interface tipm_cfg_if import tipm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/tipm_step.sv =====
`timescale 1ns / 1ps

module tipm_step import tipm_pkg::*; #(
    parameter int LOCK_BITS = LOCK_BITS_DEF
) (
    input  item_t                 item,
    input  cfg_t                  cfg,
    input  pm_state_t             state,
    input  logic [LOCK_BITS-1:0]  lock_mask,
    output pm_state_t             state_next,
    output logic [LOCK_BITS-1:0]  lock_mask_next,
    output result_t               result
);

    logic [COUNT_W-1:0]   count_inc;
    logic                 tiers_held;
    logic                 dim_hit;
    logic                 off_hit;
    logic                 sleep_hit;
    tier_t                tier_a;
    tier_t                tier_b;
    tier_t                tier_c;
    logic [LEVEL_W-1:0]   quarter;
    logic [LEVEL_W-1:0]   dim_level;
    logic [LOCK_BITS-1:0] bits;

    // lock bits resized to the mask width
    always_comb
    begin
        bits = '0;
        for (int i = 0; i < LOCK_BITS && i < LOCK_IN_W; i++)
        begin
            bits[i] = item.lock_bits[i];
        end
    end

    assign count_inc    = (state.idle_count != COUNT_MAX) ? state.idle_count + 1'b1
                                                          : state.idle_count;
    assign tiers_held   = (lock_mask != '0) || !cfg.sleep_enabled;
    assign quarter      = item.brightness_now >> DIM_SHIFT;
    assign dim_level    = (quarter < DIM_FLOOR) ? DIM_FLOOR : quarter;

    // tiers chain within one tick: dim, then off, then sleep
    assign dim_hit   = !tiers_held && (state.tier == TIER_ACTIVE)
                       && (count_inc > cfg.dim_after_ms);
    assign tier_a    = dim_hit ? TIER_DIM : state.tier;
    assign off_hit   = !tiers_held && (tier_a == TIER_DIM)
                       && (count_inc > cfg.off_after_ms);
    assign tier_b    = off_hit ? TIER_OFF : tier_a;
    assign sleep_hit = !tiers_held && !item.wifi_busy && (tier_b == TIER_OFF)
                       && (count_inc > cfg.sleep_after_ms);
    assign tier_c    = sleep_hit ? TIER_SLEEP : tier_b;

    always_comb
    begin
        state_next     = state;
        lock_mask_next = lock_mask;
        result         = '0;
        case (item.kind)
            KIND_TICK:
            begin
                state_next.idle_count = count_inc;
                state_next.tier       = tier_c;
                if (dim_hit)
                begin
                    state_next.saved_level = item.brightness_now;
                end
                if (off_hit)
                begin
                    state_next.panel_state = 1'b0;
                end
                result.backlight_write = dim_hit || off_hit;
                result.backlight_level = off_hit ? '0 : (dim_hit ? dim_level : '0);
                result.sleep_request   = sleep_hit;
            end
            KIND_TOUCH:
            begin
                state_next.idle_count = '0;
                if (state.tier != TIER_ACTIVE)
                begin
                    state_next.tier        = TIER_ACTIVE;
                    state_next.panel_state = 1'b1;
                    result.backlight_write = 1'b1;
                    result.backlight_level = state.saved_level;
                    result.touch_recal     = (state.tier inside {TIER_OFF, TIER_SLEEP});
                end
            end
            KIND_LOCK_SET:
            begin
                lock_mask_next = lock_mask | bits;
            end
            KIND_LOCK_CLR:
            begin
                lock_mask_next = lock_mask & ~bits;
            end
            default:
            begin
                lock_mask_next = lock_mask;
            end
        endcase
        result.tier            = state_next.tier;
        result.panel_on        = state_next.panel_state;
        result.display_showing = (state_next.tier inside {TIER_ACTIVE, TIER_DIM});
    end

endmodule

// ===== design/tiered_inactivity_power_manager_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload
// item_ch   in   kind, lock_bits, wifi_busy, brightness_now
// result_ch out  tier, backlight_write, backlight_level, panel_on,
//                sleep_request, touch_recal, display_showing
// cfg_ch    in   index, data (register write)
//
// One item per cycle sustained while result_ch is ready; each transfer passes the input
// register, then the state update into the result register.
// The state update is a single pass of compares on the 16-bit idle count.
// Reset restores the register defaults and the active tier; no clearing pass.
// A stall on result_ch fills the input register, then drops item_ch.ready.

`include "tiered_inactivity_power_manager_unit_defines.svh"

module tiered_inactivity_power_manager_unit import tipm_pkg::*; #(
    parameter int LOCK_BITS = LOCK_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    tipm_item_if.sink      item_ch,
    tipm_result_if.source  result_ch,
    tipm_cfg_if.sink       cfg_ch
);

    cfg_t                 cfg_reg;
    pm_state_t            state_reg;
    pm_state_t            state_next;
    logic [LOCK_BITS-1:0] lock_mask_reg;
    logic [LOCK_BITS-1:0] lock_mask_next;
    logic                 stage_valid_reg;
    item_t                stage_reg;
    logic                 res_valid_reg;
    result_t              res_reg;
    result_t              res_next;
    logic                 advance;
    item_t                item_in;

    assign advance       = stage_valid_reg && (!res_valid_reg || result_ch.ready);
    assign item_ch.ready = !stage_valid_reg || advance;
    assign cfg_ch.ready  = 1'b1;

    assign item_in.kind           = kind_t'(item_ch.kind);
    assign item_in.lock_bits      = item_ch.lock_bits;
    assign item_in.wifi_busy      = item_ch.wifi_busy;
    assign item_in.brightness_now = item_ch.brightness_now;

    tipm_step #(
        .LOCK_BITS (LOCK_BITS)
    ) u_step (
        .item           (stage_reg),
        .cfg            (cfg_reg),
        .state          (state_reg),
        .lock_mask      (lock_mask_reg),
        .state_next     (state_next),
        .lock_mask_next (lock_mask_next),
        .result         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_after_ms   <= DIM_AFTER_RST;
            cfg_reg.off_after_ms   <= OFF_AFTER_RST;
            cfg_reg.sleep_after_ms <= SLEEP_AFTER_RST;
            cfg_reg.sleep_enabled  <= 1'b1;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                CFG_DIM_AFTER:   cfg_reg.dim_after_ms   <= cfg_ch.data;
                CFG_OFF_AFTER:   cfg_reg.off_after_ms   <= cfg_ch.data;
                CFG_SLEEP_AFTER: cfg_reg.sleep_after_ms <= cfg_ch.data;
                CFG_SLEEP_EN:    cfg_reg.sleep_enabled  <= cfg_ch.data[0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.tier        <= TIER_ACTIVE;
            state_reg.idle_count  <= '0;
            state_reg.saved_level <= SAVED_RST;
            state_reg.panel_state <= 1'b1;
            lock_mask_reg         <= '0;
            stage_valid_reg       <= 1'b0;
            res_valid_reg         <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                lock_mask_reg <= lock_mask_next;
                res_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_ch.valid && item_ch.ready)
        begin
            stage_reg <= item_in;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_ch.valid           = res_valid_reg;
    assign result_ch.tier            = res_reg.tier;
    assign result_ch.backlight_write = res_reg.backlight_write;
    assign result_ch.backlight_level = res_reg.backlight_level;
    assign result_ch.panel_on        = res_reg.panel_on;
    assign result_ch.sleep_request   = res_reg.sleep_request;
    assign result_ch.touch_recal     = res_reg.touch_recal;
    assign result_ch.display_showing = res_reg.display_showing;

    // panel is powered exactly in the showing tiers
    `TIPM_ASSERT_IMP(a_panel_tier, 1'b1,
        state_reg.panel_state == (state_reg.tier == TIER_ACTIVE || state_reg.tier == TIER_DIM))
    // lock items never move the tier
    `TIPM_ASSERT_NEXT(a_lock_keeps_tier,
        advance && (stage_reg.kind == KIND_LOCK_SET || stage_reg.kind == KIND_LOCK_CLR),
        $stable(state_reg.tier))
    `TIPM_ASSERT_IMP(a_sleep_req_tier, res_valid_reg && res_reg.sleep_request,
        res_reg.tier == TIER_SLEEP && !res_reg.panel_on)
    `TIPM_ASSERT_IMP(a_recal_wakes, res_valid_reg && res_reg.touch_recal,
        res_reg.tier == TIER_ACTIVE && res_reg.panel_on && res_reg.backlight_write)
    `TIPM_ASSERT_IMP(a_level_zero_idle, res_valid_reg && !res_reg.backlight_write,
        res_reg.backlight_level == '0)

endmodule
